### hdl/sigmoid_activation_unit_top_macros.svh
// Assertion macros used by the sigmoid activation unit top level.
`ifndef SIGMOID_ACTIVATION_UNIT_TOP_MACROS_SVH
`define SIGMOID_ACTIVATION_UNIT_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SAU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sau_pkg.sv
// Shared types, constants and the interpolation knot table of the sigmoid unit.
package sau_pkg;

	localparam int DATA_W     = 16;
	localparam int SIG_W      = 15;
	localparam int SEGMENTS   = 32;
	// Segment count is a power of two, so the segment index is the top bits of x's offset above -8.0.
	localparam int SEG_BITS   = $clog2(SEGMENTS);
	localparam int SEG_W_BITS = DATA_W - SEG_BITS;
	localparam int NUM_W      = DATA_W + SEG_W_BITS + 1;
	localparam int YC_W       = 2 * SIG_W - 1;
	localparam int PROD_W     = DATA_W + YC_W;
	localparam int BWD_SHIFT  = 2 * SIG_W;
	localparam int TDATA_W    = 32;

	localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF = 64'd1 << 29;

	typedef enum logic {
		CMD_FWD = 1'b0,
		CMD_BWD = 1'b1
	} cmd_t;

	typedef logic [SEGMENTS:0][SIG_W-1:0] knot_tab_t;

	// Stage one: table lookup done, y*(1-y) formed.
	typedef struct packed {
		cmd_t                    cmd;
		logic                    last;
		logic [SIG_W-1:0]        v0;
		logic signed [DATA_W-1:0] dv;
		logic [SEG_W_BITS-1:0]   t;
		logic [DATA_W-1:0]       mag;
		logic                    neg;
		logic [YC_W-1:0]         yc;
	} s1_t;

	// Stage two: products formed.
	typedef struct packed {
		cmd_t                    cmd;
		logic                    last;
		logic [SIG_W-1:0]        v0;
		logic signed [NUM_W-1:0] num;
		logic [PROD_W-1:0]       prod;
		logic                    neg;
	} s2_t;

	// Shift-subtract division, used only while the knot table is built.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-a/4096) in Q30: short series on a/1048576, then eight squarings.
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] u3;
		logic [63:0] u4;
		logic [63:0] s;
		u = a << 10;
		u2 = (u * u) >> 30;
		u3 = (u2 * u) >> 30;
		u4 = (u3 * u) >> 30;
		s = Q30_ONE - u + u2 / 64'd2 - u3 / 64'd6 + u4 / 64'd24;
		for (int i = 0; i < 8; i++) begin
			s = (s * s + Q30_HALF) >> 30;
		end
		return s;
	endfunction

	// Sigmoid in Q1.15 at each evenly spaced knot over [-8, +8].
	function automatic knot_tab_t build_knots();
		knot_tab_t tab;
		logic [63:0] pos;
		logic [63:0] a;
		logic [63:0] d;
		logic [63:0] v;
		logic        below;
		for (int k = 0; k <= SEGMENTS; k++) begin
			pos = 64'(k) << SEG_W_BITS;
			below = (pos < 64'd32768);
			a = below ? (64'd32768 - pos) : (pos - 64'd32768);
			if (a > 64'd32768) begin
				a = 64'd32768;
			end
			d = Q30_ONE + exp_neg_q30(a);
			v = udiv64((64'd1 << 45) + (d >> 1), d);
			if (below) begin
				v = (v > 64'd32768) ? 64'd0 : (64'd32768 - v);
			end
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			tab[k] = v[SIG_W-1:0];
		end
		return tab;
	endfunction

	localparam knot_tab_t KNOTS = build_knots();

endpackage

### hdl/sau_prep.sv
// First pipeline stage: knot lookup for forward items, y*(1-y) for backward items.
module sau_prep (
	input  logic                          clk,
	input  logic                          en,
	input  sau_pkg::cmd_t                 cmd,
	input  logic [sau_pkg::DATA_W-1:0]    x_or_grad,
	input  logic [sau_pkg::SIG_W-1:0]     sig_value,
	input  logic                          last_in,
	output sau_pkg::s1_t                  stage_s1
);
	import sau_pkg::*;

	logic [DATA_W-1:0]     offs;
	logic [SEG_BITS-1:0]   seg;
	logic [SEG_BITS:0]     seg_next;
	logic [SIG_W-1:0]      v0;
	logic [SIG_W-1:0]      v1;
	logic [DATA_W-1:0]     comp;
	logic [SIG_W+DATA_W-1:0] yc_full;
	s1_t                   nxt;

	// Flipping the sign bit turns x into its offset above -8.0.
	assign offs     = {~x_or_grad[DATA_W-1], x_or_grad[DATA_W-2:0]};
	assign seg      = offs[DATA_W-1:SEG_W_BITS];
	assign seg_next = {1'b0, seg} + (SEG_BITS+1)'(1);
	assign v0       = KNOTS[{1'b0, seg}];
	assign v1       = KNOTS[seg_next];
	assign comp     = (DATA_W)'(1 << SIG_W) - {1'b0, sig_value};
	assign yc_full  = sig_value * comp;

	always_comb begin
		nxt.cmd  = cmd;
		nxt.last = last_in;
		nxt.v0   = v0;
		nxt.dv   = $signed({1'b0, v1}) - $signed({1'b0, v0});
		nxt.t    = offs[SEG_W_BITS-1:0];
		nxt.mag  = x_or_grad[DATA_W-1] ? (~x_or_grad + (DATA_W)'(1)) : x_or_grad;
		nxt.neg  = x_or_grad[DATA_W-1];
		nxt.yc   = yc_full[YC_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s1 <= nxt;
		end
	end

endmodule

### hdl/sau_mul.sv
// Second pipeline stage: interpolation product and gradient product.
module sau_mul (
	input  logic         clk,
	input  logic         en,
	input  sau_pkg::s1_t stage_s1,
	output sau_pkg::s2_t stage_s2
);
	import sau_pkg::*;

	s2_t nxt;

	always_comb begin
		nxt.cmd  = stage_s1.cmd;
		nxt.last = stage_s1.last;
		nxt.v0   = stage_s1.v0;
		// Both products are formed at full width so no high bits are lost.
		nxt.num  = (NUM_W)'(stage_s1.dv)
			* $signed({{(NUM_W-SEG_W_BITS){1'b0}}, stage_s1.t});
		nxt.prod = {{(PROD_W-DATA_W){1'b0}}, stage_s1.mag}
			* {{(PROD_W-YC_W){1'b0}}, stage_s1.yc};
		nxt.neg  = stage_s1.neg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s2 <= nxt;
		end
	end

endmodule

### hdl/sau_post.sv
// Third pipeline stage: rounding, sign and clamping into the result register.
module sau_post (
	input  logic                           clk,
	input  logic                           en,
	input  sau_pkg::s2_t                   stage_s2,
	output logic [sau_pkg::DATA_W-1:0]     result_s3,
	output logic                           last_s3
);
	import sau_pkg::*;

	logic [NUM_W-1:0]        anum;
	logic [NUM_W-1:0]        q;
	logic signed [NUM_W:0]   ysum;
	logic [SIG_W-1:0]        yclamp;
	logic [PROD_W:0]         prod_rnd;
	logic [DATA_W-1:0]       r;
	logic [DATA_W-1:0]       res;

	// Forward: divide by the segment width with rounding half away from zero.
	assign anum = stage_s2.num[NUM_W-1] ? (~stage_s2.num + (NUM_W)'(1)) : stage_s2.num;
	assign q    = (anum + (NUM_W)'(1 << (SEG_W_BITS - 1))) >> SEG_W_BITS;
	assign ysum = stage_s2.num[NUM_W-1]
		? ($signed({2'b00, (NUM_W-1)'(stage_s2.v0)}) - $signed({1'b0, q}))
		: ($signed({2'b00, (NUM_W-1)'(stage_s2.v0)}) + $signed({1'b0, q}));

	always_comb begin
		if (ysum < 0) begin
			yclamp = '0;
		end else if (ysum > $signed((NUM_W+1)'((1 << SIG_W) - 1))) begin
			yclamp = '1;
		end else begin
			yclamp = ysum[SIG_W-1:0];
		end
	end

	// Backward: the product is at most 2^43, so the Q4.12 result stays within +-8192.
	assign prod_rnd = {1'b0, stage_s2.prod} + (PROD_W+1)'(64'd1 << (BWD_SHIFT - 1));
	assign r        = (DATA_W)'(prod_rnd >> BWD_SHIFT);
	assign res      = stage_s2.neg ? (~r + (DATA_W)'(1)) : r;

	always_ff @(posedge clk) begin
		if (en) begin
			result_s3 <= (stage_s2.cmd == CMD_FWD) ? {1'b0, yclamp} : res;
			last_s3   <= stage_s2.last;
		end
	end

endmodule

### hdl/sigmoid_activation_unit_top.sv
// Top level of the sigmoid activation unit: stream ports and pipeline valid control.
//
// One input transaction on the s_axis group carries one tensor element; one
// output transaction on the m_axis group returns its result, in the same order.
// tuser selects the operation: forward sigmoid or backward gradient. Forward
// takes x in Q4.12 and returns sigmoid(x) in Q1.15 by linear interpolation
// between 33 knots over [-8, +8]. Backward takes a Q4.12 gradient and a stored
// Q1.15 sigmoid value and returns grad*y*(1-y) in Q4.12, rounded half away
// from zero. tlast passes through with its element.
// One transaction is accepted every cycle while the output is taken. The three
// stages are the knot lookup, the multiply, and the rounding and clamp.
// Reset clears the stage valid bits only; the stage data registers are not reset.
// When the receiver holds m_axis_tready low, the result waits in the output
// register and the stages behind it keep filling; s_axis_tready drops only once
// all three stages hold a transaction.
module sigmoid_activation_unit_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sau_pkg::TDATA_W-1:0]      s_axis_tdata,  // [15:0] x_or_grad, [30:16] sig_value
	input  logic                             s_axis_tuser,  // [0] cmd
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [sau_pkg::DATA_W-1:0]       m_axis_tdata,  // [15:0] result_value
	output logic                             m_axis_tlast
);
	import sau_pkg::*;

	`include "sigmoid_activation_unit_top_macros.svh"

	logic  valid_s1;
	logic  valid_s2;
	logic  valid_s3;
	logic  adv1;
	logic  adv2;
	logic  adv3;
	cmd_t  cmd;
	s1_t   stage_s1;
	s2_t   stage_s2;

	// A stage moves forward when it is empty or the one after it moves.
	assign adv3 = !valid_s3 || m_axis_tready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign s_axis_tready = adv1;
	assign m_axis_tvalid = valid_s3;
	assign cmd           = cmd_t'(s_axis_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	sau_prep u_prep (
		.clk       (clk),
		.en        (adv1),
		.cmd       (cmd),
		.x_or_grad (s_axis_tdata[DATA_W-1:0]),
		.sig_value (s_axis_tdata[DATA_W+SIG_W-1:DATA_W]),
		.last_in   (s_axis_tlast),
		.stage_s1  (stage_s1)
	);

	sau_mul u_mul (
		.clk      (clk),
		.en       (adv2),
		.stage_s1 (stage_s1),
		.stage_s2 (stage_s2)
	);

	sau_post u_post (
		.clk       (clk),
		.en        (adv3),
		.stage_s2  (stage_s2),
		.result_s3 (m_axis_tdata),
		.last_s3   (m_axis_tlast)
	);

	`SAU_ASSERT_NXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, valid_s1, "accepted transaction did not reach stage one")
	`SAU_ASSERT_IMP(a_full_stall_blocks, valid_s1 && valid_s2 && valid_s3 && !m_axis_tready, !s_axis_tready, "input taken while pipeline full and stalled")
	`SAU_ASSERT_NXT(a_s2_held, valid_s2 && !adv2, valid_s2, "stalled stage two transaction was lost")
	`SAU_ASSERT_IMP(a_out_from_s2, $rose(m_axis_tvalid), $past(valid_s2), "result appeared without a transaction in stage two")

endmodule

### sim/sau_stream_checker.sv
// Checker for the sigmoid activation unit: predicts each element's result and compares the output.
`timescale 1ns / 1ps

module sau_stream_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [sau_pkg::TDATA_W-1:0]   s_axis_tdata,  // [15:0] x_or_grad, [30:16] sig_value
	input  logic                          s_axis_tuser,  // [0] cmd
	input  logic                          s_axis_tlast,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [sau_pkg::DATA_W-1:0]    m_axis_tdata,  // [15:0] result_value
	input  logic                          m_axis_tlast,
	output int                            errors,
	output int                            pending,
	output int                            fwd_checked,
	output int                            bwd_checked,
	output int                            ends_checked
);
	import sau_pkg::*;

	localparam longint unsigned ONE_Q30  = 64'd1 << 30;
	localparam longint unsigned HALF_Q30 = 64'd1 << 29;
	localparam longint          OUT_MAX  = (64'sd1 <<< (DATA_W - 1)) - 1;
	localparam longint          OUT_MIN  = -OUT_MAX - 1;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} elem_result_t;

	elem_result_t   awaited_results[$];
	longint         sigmoid_knot_q15[0:SEGMENTS];

	// exp(-a/4096) in Q30: five series terms on a/1048576, then eight squarings.
	function automatic longint unsigned exp_decay_q30(input longint unsigned a);
		longint unsigned u;
		longint unsigned u2;
		longint unsigned u3;
		longint unsigned u4;
		longint unsigned s;
		u = a << 10;
		u2 = (u * u) >> 30;
		u3 = (u2 * u) >> 30;
		u4 = (u3 * u) >> 30;
		s = ONE_Q30 - u + u2 / 2 - u3 / 6 + u4 / 24;
		repeat (8) s = (s * s + HALF_Q30) >> 30;
		return s;
	endfunction

	function automatic longint knot_offset(input longint k);
		return (k * 65536) / SEGMENTS;
	endfunction

	function automatic longint knot_sigmoid(input longint k);
		longint          xpos;
		longint unsigned a;
		longint unsigned d;
		longint unsigned v;
		xpos = knot_offset(k) - 32768;
		a = (xpos < 0) ? longint'(-xpos) : longint'(xpos);
		if (a > 32768)
			a = 32768;
		d = ONE_Q30 + exp_decay_q30(a);
		v = ((64'd1 << 45) + (d >> 1)) / d;
		if (xpos < 0)
			v = (v > 32768) ? 0 : 32768 - v;
		if (v > 32767)
			v = 32767;
		return longint'(v);
	endfunction

	function automatic longint sigmoid_q15(input logic signed [DATA_W-1:0] x);
		longint o;
		longint k;
		longint p0;
		longint w;
		longint t;
		longint v0;
		longint dv;
		longint num;
		longint q;
		longint y;
		o = longint'(x) + 32768;
		k = (o * SEGMENTS) >>> 16;
		p0 = knot_offset(k);
		w = knot_offset(k + 1) - p0;
		t = o - p0;
		v0 = sigmoid_knot_q15[k];
		dv = sigmoid_knot_q15[k + 1] - v0;
		num = dv * t;
		// Interpolation step rounds half away from zero.
		if (w <= 0)
			q = 0;
		else if (num >= 0)
			q = (num + w / 2) / w;
		else
			q = -((-num + w / 2) / w);
		y = v0 + q;
		if (y < 0)
			y = 0;
		if (y > 32767)
			y = 32767;
		if (y > OUT_MAX)
			y = OUT_MAX;
		return y;
	endfunction

	function automatic longint sigmoid_grad_q12(input logic signed [DATA_W-1:0] g,
			input logic [SIG_W-1:0] y);
		longint unsigned mag;
		longint unsigned yy;
		longint unsigned prod;
		longint unsigned r;
		longint          res;
		mag = (g < 0) ? longint'(-longint'(g)) : longint'(g);
		yy = y;
		prod = mag * (yy * (32768 - yy));
		r = (prod + HALF_Q30) >> 30;
		if (r > (64'd1 << 40))
			r = 64'd1 << 40;
		res = (g < 0) ? -longint'(r) : longint'(r);
		if (res > OUT_MAX)
			res = OUT_MAX;
		if (res < OUT_MIN)
			res = OUT_MIN;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		fwd_checked = 0;
		bwd_checked = 0;
		ends_checked = 0;
		for (int k = 0; k <= SEGMENTS; k++) begin
			sigmoid_knot_q15[k] = knot_sigmoid(k);
		end
	end

	always @(posedge clk) begin
		elem_result_t             pred;
		elem_result_t             head;
		logic signed [DATA_W-1:0] xg;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pred.cmd = cmd_t'(s_axis_tuser);
				pred.last = s_axis_tlast;
				xg = s_axis_tdata[DATA_W-1:0];
				if (pred.cmd == CMD_FWD)
					pred.value = DATA_W'(sigmoid_q15(xg));
				else
					pred.value = DATA_W'(sigmoid_grad_q12(xg, s_axis_tdata[DATA_W +: SIG_W]));
				awaited_results.push_back(pred);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result transaction with no element outstanding",
						longint'($signed(m_axis_tdata)), 0);
				end else begin
					head = awaited_results.pop_front();
					if (m_axis_tdata !== head.value)
						report_mismatch(head.cmd == CMD_FWD ? "forward sigmoid value"
							: "backward gradient value",
							longint'($signed(m_axis_tdata)), longint'(head.value));
					if (m_axis_tlast !== head.last)
						report_mismatch("tlast", longint'(m_axis_tlast), longint'(head.last));
					if (head.cmd == CMD_FWD)
						fwd_checked++;
					else
						bwd_checked++;
					if (head.last)
						ends_checked++;
				end
			end
			pending = awaited_results.size();
		end
	end

endmodule

### sim/sigmoid_activation_unit_top_tb.sv
// Testbench top for the sigmoid activation unit: clock, reset, stream stimulus and verdict.
`timescale 1ns / 1ps

module sigmoid_activation_unit_top_tb;
	import sau_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 10;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata;
	logic                s_axis_tuser;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [DATA_W-1:0]   m_axis_tdata;
	logic                m_axis_tlast;

	int errors;
	int pending;
	int fwd_checked;
	int bwd_checked;
	int ends_checked;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;

	sigmoid_activation_unit_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	sau_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending),
		.fwd_checked   (fwd_checked),
		.bwd_checked   (bwd_checked),
		.ends_checked  (ends_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver side: backpressure drawn fresh every cycle.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Presents one element and holds it until the transaction completes.
	task automatic send_element(input cmd_t cmd, input logic signed [DATA_W-1:0] xg,
			input logic [SIG_W-1:0] y, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, y, xg};
		s_axis_tuser  <= cmd;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_element();
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] xg;
		logic [SIG_W-1:0]         y;
		int                       pick;
		cmd = cmd_t'($urandom_range(1));
		pick = $urandom_range(9);
		if (pick == 0) begin
			case ($urandom_range(3))
				0: xg = 16'sh8000;
				1: xg = 16'sh7FFF;
				2: xg = '0;
				default: xg = '1;
			endcase
		end else if (pick <= 3) begin
			// Land on or right beside a knot, where segment selection changes.
			xg = DATA_W'(($urandom_range(SEGMENTS - 1) << SEG_W_BITS) + 32768
				+ $urandom_range(6) - 3);
		end else begin
			xg = DATA_W'($urandom);
		end
		case ($urandom_range(7))
			0: y = '0;
			1: y = '1;
			2: y = 15'd16384;
			default: y = SIG_W'($urandom);
		endcase
		send_element(cmd, xg, y, $urandom_range(15) == 0);
	endtask

	initial begin
		cycle_count = 0;
		send_idle_pct = 11;
		recv_idle_pct = 78;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Forward: both ends of the domain, zero, and knot and mid-segment points.
		send_element(CMD_FWD, 16'sh8000, 15'd0, 1'b0);
		send_element(CMD_FWD, 16'sh7FFF, 15'h7FFF, 1'b0);
		send_element(CMD_FWD, 16'sd0, 15'd0, 1'b1);
		send_element(CMD_FWD, -16'sd1, 15'd0, 1'b0);
		send_element(CMD_FWD, 16'sd1, 15'd0, 1'b0);
		send_element(CMD_FWD, 16'sd2048, 15'd0, 1'b0);
		send_element(CMD_FWD, -16'sd2048, 15'd0, 1'b0);
		send_element(CMD_FWD, 16'sd1024, 15'd0, 1'b0);
		send_element(CMD_FWD, 16'sd30720, 15'd0, 1'b0);
		send_element(CMD_FWD, 16'sd32000, 15'd0, 1'b0);
		send_element(CMD_FWD, -16'sd30721, 15'h5555, 1'b1);
		// Backward: largest products of both signs, zero terms, and rounding edges.
		send_element(CMD_BWD, 16'sh7FFF, 15'd16384, 1'b0);
		send_element(CMD_BWD, 16'sh8000, 15'd16384, 1'b0);
		send_element(CMD_BWD, 16'sh8000, 15'd16383, 1'b0);
		send_element(CMD_BWD, 16'sd0, 15'd16384, 1'b0);
		send_element(CMD_BWD, 16'sh7FFF, 15'd0, 1'b0);
		send_element(CMD_BWD, 16'sh7FFF, 15'h7FFF, 1'b0);
		send_element(CMD_BWD, 16'sh8000, 15'h7FFF, 1'b0);
		send_element(CMD_BWD, -16'sd1, 15'd16384, 1'b0);
		send_element(CMD_BWD, 16'sd1, 15'd1, 1'b0);
		send_element(CMD_BWD, 16'sd2, 15'd16384, 1'b0);
		send_element(CMD_BWD, -16'sd4096, 15'h2AAA, 1'b1);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 78;
				recv_idle_pct = 11;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_random_element();
		end
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d forward and %0d backward elements, %0d of them tensor ends,",
			fwd_checked, bwd_checked, ends_checked);
		$display("with sender and receiver stalls swapped between phases, then full rate.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/sau_pkg.sv
hdl/sau_prep.sv
hdl/sau_mul.sv
hdl/sau_post.sv
hdl/sigmoid_activation_unit_top.sv
sim/sau_stream_checker.sv
sim/sigmoid_activation_unit_top_tb.sv
